[sv/mirp_pkg.sv]
// Shared types and constants for the MIDI identity reply parser.
`default_nettype none

package mirp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned DEVICE_W  = 7;
  localparam int unsigned CODE_W    = 15;
  localparam int unsigned VERSION_W = 31;
  localparam int unsigned TDATA_W   = 88;

  localparam logic [BYTE_W-1:0] MSG_START    = 8'hF0;
  localparam logic [BYTE_W-1:0] MSG_END      = 8'hF7;
  localparam logic [BYTE_W-1:0] UNIVERSAL_ID = 8'h7E;
  localparam logic [BYTE_W-1:0] SUB_GENERAL  = 8'h06;
  localparam logic [BYTE_W-1:0] SUB_REPLY    = 8'h02;
  localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;

  // Byte positions inside the message
  localparam logic [POS_W-1:0] POS_START    = 5'd0;
  localparam logic [POS_W-1:0] POS_UNIV     = 5'd1;
  localparam logic [POS_W-1:0] POS_DEVICE   = 5'd2;
  localparam logic [POS_W-1:0] POS_SUB1     = 5'd3;
  localparam logic [POS_W-1:0] POS_SUB2     = 5'd4;
  localparam logic [POS_W-1:0] POS_MAKER    = 5'd5;
  localparam logic [POS_W-1:0] POS_MAKER_HI = 5'd6;
  localparam logic [POS_W-1:0] POS_MAKER_LO = 5'd7;
  localparam logic [POS_W-1:0] BASE_SHORT   = 5'd6;
  localparam logic [POS_W-1:0] BASE_LONG    = 5'd8;
  localparam logic [POS_W-1:0] POS_MAX      = 5'd31;
  // Last-byte position limits (length minus one)
  localparam logic [POS_W-1:0] MIN_LAST_SHORT = 5'd14;
  localparam logic [POS_W-1:0] MIN_LAST_LONG  = 5'd16;

  // Offsets of the fields after the manufacturer ID
  localparam logic [POS_W-1:0] OFF_FAMILY_LO = 5'd0;
  localparam logic [POS_W-1:0] OFF_FAMILY_HI = 5'd1;
  localparam logic [POS_W-1:0] OFF_MODEL_LO  = 5'd2;
  localparam logic [POS_W-1:0] OFF_MODEL_HI  = 5'd3;
  localparam logic [POS_W-1:0] OFF_VER_3     = 5'd4;
  localparam logic [POS_W-1:0] OFF_VER_2     = 5'd5;
  localparam logic [POS_W-1:0] OFF_VER_1     = 5'd6;
  localparam logic [POS_W-1:0] OFF_VER_0     = 5'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    logic [DEVICE_W-1:0]  device_id;
    logic [CODE_W-1:0]    maker_id;
    logic [CODE_W-1:0]    family_code;
    logic [CODE_W-1:0]    model_code;
    logic [VERSION_W-1:0] version_word;
  } result_t;

endpackage

`default_nettype wire

[sv/midi_identity_reply_parser_unit.sv]
// Top level of the MIDI universal identity reply parser.
// A final byte's result passes from the input register to the result register.
// Throughput: one byte item per cycle unless a final byte waits; inner bytes never wait on the output.
// A final byte waits in the input register only while the result register
// holds an untaken result. Reset (rst_ni low, async) clears the position,
// check flags, captured fields and both valid flags.
`default_nettype none

module midi_identity_reply_parser_unit
  import mirp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [BYTE_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic               s_axis_tlast_i,   // final_byte
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [6:0] device_id, [21:7] maker_id, [36:22] family_code,
  // [51:37] model_code, [82:52] version_word, [87:83] zero
  output logic [TDATA_W-1:0]      m_axis_tdata_o,
  output logic                    m_axis_tuser_o    // accepted
);

  item_t   in_item, cur_item;
  logic    cur_valid, take, out_free, load;
  result_t res_d, res_q;

  assign in_item.data_byte  = s_axis_tdata_i;
  assign in_item.final_byte = s_axis_tlast_i;

  assign take = cur_valid && (!cur_item.final_byte || out_free);
  assign load = take && cur_item.final_byte;

  mirp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  mirp_field_capture u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (cur_item),
    .result_o (res_d)
  );

  mirp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (res_d),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (res_q)
  );

  assign m_axis_tuser_o = res_q.accepted;
  assign m_axis_tdata_o = {5'd0, res_q.version_word, res_q.model_code, res_q.family_code,
                           res_q.maker_id, res_q.device_id};

endmodule

`default_nettype wire

[sv/mirp_in_reg.sv]
// Input register stage holding one incoming byte item.
`default_nettype none

module mirp_in_reg
  import mirp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[sv/mirp_field_capture.sv]
// Per-byte checks, field capture and the result of a finished message.
`default_nettype none

module mirp_field_capture
  import mirp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  take_i,
  input  wire item_t item_i,
  output result_t    result_o
);

  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 failed_q, failed_d;
  logic                 long_q, long_d;
  logic [DEVICE_W-1:0]  device_q, device_d;
  logic [CODE_W-1:0]    maker_q, maker_d;
  logic [CODE_W-1:0]    family_q, family_d;
  logic [CODE_W-1:0]    model_q, model_d;
  logic [VERSION_W-1:0] version_q, version_d;

  logic [BYTE_W-1:0] b;
  logic [6:0]        v;
  logic [POS_W-1:0]  base;
  logic [POS_W-1:0]  offs;
  logic              ok;

  assign b    = item_i.data_byte;
  assign v    = b[6:0];
  assign base = long_q ? BASE_LONG : BASE_SHORT;
  assign offs = pos_q - base;

  always_comb begin
    ok = !failed_q && (b == MSG_END) && (pos_q >= MIN_LAST_SHORT) &&
         (!long_q || (pos_q >= MIN_LAST_LONG));
    result_o = '0;
    if (ok) begin
      result_o.accepted     = 1'b1;
      result_o.device_id    = device_q;
      result_o.maker_id     = maker_q;
      result_o.family_code  = family_q;
      result_o.model_code   = model_q;
      result_o.version_word = version_q;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    failed_d  = failed_q;
    long_d    = long_q;
    device_d  = device_q;
    maker_d   = maker_q;
    family_d  = family_q;
    model_d   = model_q;
    version_d = version_q;
    if (item_i.final_byte) begin
      // message done: back to the idle state for the next one
      pos_d     = '0;
      failed_d  = 1'b0;
      long_d    = 1'b0;
      device_d  = '0;
      maker_d   = '0;
      family_d  = '0;
      model_d   = '0;
      version_d = '0;
    end else begin
      pos_d = (pos_q == POS_MAX) ? POS_MAX : pos_q + 5'd1;
      if (pos_q == POS_START) begin
        if (b != MSG_START) failed_d = 1'b1;
      end else begin
        if (b[7]) failed_d = 1'b1;
        if (pos_q == POS_UNIV && b != UNIVERSAL_ID) failed_d = 1'b1;
        if (pos_q == POS_SUB1 && b != SUB_GENERAL) failed_d = 1'b1;
        if (pos_q == POS_SUB2 && b != SUB_REPLY) failed_d = 1'b1;
        if (pos_q == POS_DEVICE) device_d = v;
        if (pos_q == POS_MAKER) begin
          if (b == ZERO_BYTE) begin
            long_d  = 1'b1;
            maker_d = '0;
          end else begin
            maker_d = {8'd0, v};
          end
        end else if (long_q && pos_q == POS_MAKER_HI) begin
          maker_d[14:8] = v;
        end else if (long_q && pos_q == POS_MAKER_LO) begin
          maker_d[6:0] = v;
        end else if (pos_q >= base) begin
          // each part is written once per message over cleared state
          case (offs)
            OFF_FAMILY_LO: family_d = {8'd0, v};
            OFF_FAMILY_HI: family_d[14:8] = v;
            OFF_MODEL_LO:  model_d = {8'd0, v};
            OFF_MODEL_HI:  model_d[14:8] = v;
            OFF_VER_3:     version_d[30:24] = v;
            OFF_VER_2:     version_d[22:16] = v;
            OFF_VER_1:     version_d[14:8] = v;
            OFF_VER_0:     version_d[6:0] = v;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      failed_q  <= 1'b0;
      long_q    <= 1'b0;
      device_q  <= '0;
      maker_q   <= '0;
      family_q  <= '0;
      model_q   <= '0;
      version_q <= '0;
    end else if (take_i) begin
      pos_q     <= pos_d;
      failed_q  <= failed_d;
      long_q    <= long_d;
      device_q  <= device_d;
      maker_q   <= maker_d;
      family_q  <= family_d;
      model_q   <= model_d;
      version_q <= version_d;
    end
  end

endmodule

`default_nettype wire

[sv/mirp_out_reg.sv]
// Result register driving the output stream.
`default_nettype none

module mirp_out_reg
  import mirp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

[sv/mirp_checker.sv]
// Port-level assertions for the identity reply parser, bound to the top level.
`default_nettype none

module mirp_checker
  import mirp_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [TDATA_W-1:0] m_axis_tdata_o,
  input wire logic               m_axis_tuser_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a rejected message reports all fields zero
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("rejected message carries nonzero fields");

  // captured bytes are 7-bit, so bit 7 of each byte lane below the top lane of a packed code is clear
  a_seven_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[14] && !m_axis_tdata_o[29] &&
      !m_axis_tdata_o[44] && !m_axis_tdata_o[59] && !m_axis_tdata_o[67] &&
      !m_axis_tdata_o[75])
    else $error("captured field has bit 7 set in a byte lane");

  // a reset clears the valid flag
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

endmodule

bind midi_identity_reply_parser_unit mirp_checker u_mirp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
